/* sv/flpd_pkg.sv */
// Shared types, constants and the low-pass coefficient table of the FIR-to-PWM block.
`default_nettype none

package flpd_pkg;

  localparam int SAMPLE_W     = 12;
  localparam int Q15_W        = 26;
  localparam int PWM_W        = 16;
  localparam int COEF_IDX_W   = 6;
  localparam int PWM_X_W      = 28;
  localparam int PWM_SHIFT    = 27;
  localparam int Q15_MAX_VAL  = 33554431;
  localparam int Q15_MIN_VAL  = -33554432;
  localparam logic [PWM_W-1:0] PWM_FS_RESET = 16'd16000;

  // Controls from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic                  clear;
    logic                  mul_en;
    logic [COEF_IDX_W-1:0] coef_idx;
  } mac_ctl_t;

  // Controls from the sequencer to the output scaling pipeline.
  typedef struct packed {
    logic scale_en;
    logic mul_en;
  } pwm_ctl_t;

  // Low-pass coefficients in Q1.15; taps past the end of the table are zero.
  function automatic logic signed [15:0] coef_q15(input logic [COEF_IDX_W-1:0] idx);
    logic signed [15:0] c;
    case (idx)
      6'd0:    c = -16'sd36;
      6'd1:    c = -16'sd75;
      6'd2:    c = -16'sd115;
      6'd3:    c = -16'sd147;
      6'd4:    c = -16'sd167;
      6'd5:    c = -16'sd170;
      6'd6:    c = -16'sd147;
      6'd7:    c = -16'sd95;
      6'd8:    c = 16'sd0;
      6'd9:    c = 16'sd138;
      6'd10:   c = 16'sd311;
      6'd11:   c = 16'sd505;
      6'd12:   c = 16'sd698;
      6'd13:   c = 16'sd868;
      6'd14:   c = 16'sd999;
      6'd15:   c = 16'sd1065;
      6'd16:   c = 16'sd1065;
      6'd17:   c = 16'sd999;
      6'd18:   c = 16'sd868;
      6'd19:   c = 16'sd698;
      6'd20:   c = 16'sd505;
      6'd21:   c = 16'sd311;
      6'd22:   c = 16'sd138;
      6'd23:   c = 16'sd0;
      6'd24:   c = -16'sd95;
      6'd25:   c = -16'sd147;
      6'd26:   c = -16'sd170;
      6'd27:   c = -16'sd167;
      6'd28:   c = -16'sd147;
      6'd29:   c = -16'sd115;
      6'd30:   c = -16'sd75;
      default: c = 16'sd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/flpd_cell.sv */
// One delay-line cell: holds a sample and passes it to the next cell when the row moves.
`default_nettype none

module flpd_cell
  import flpd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                shift_en,
  input  wire logic [SAMPLE_W-1:0] d_in,
  output logic      [SAMPLE_W-1:0] q
);

  logic [SAMPLE_W-1:0] q_r;

  // The history starts cleared after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (shift_en) begin
      q_r <= d_in;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

/* sv/flpd_mac.sv */
// Shared multiply-accumulate unit that consumes one tap per cycle from the end of the row.
`default_nettype none

module flpd_mac
  import flpd_pkg::*;
#(
  parameter int TAPS      = 31,
  parameter int COEF_BITS = 16,
  localparam int ACC_W    = COEF_BITS + SAMPLE_W + 1 + $clog2(TAPS + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire mac_ctl_t                ctl,
  input  wire logic [SAMPLE_W-1:0]     sample,
  output logic signed [ACC_W-1:0]      acc
);

  localparam int FRAC  = COEF_BITS - 1;
  localparam int UP    = (FRAC >= 15) ? FRAC - 15 : 0;
  localparam int DN    = (FRAC < 15) ? 15 - FRAC : 0;
  localparam int RND   = (DN > 0) ? (1 << (DN - 1)) : 0;
  localparam int PROD_W = COEF_BITS + SAMPLE_W + 1;

  int                          coef_wide;
  logic signed [COEF_BITS-1:0] coef;
  logic signed [PROD_W-1:0]    s_ext;
  logic signed [PROD_W-1:0]    c_ext;
  logic signed [PROD_W-1:0]    prod_nxt;
  logic signed [PROD_W-1:0]    prod_r;
  logic                        prod_vld_r;
  logic signed [ACC_W-1:0]     acc_r;

  // Rescale the Q1.15 coefficient: exact left shift for longer formats, round half up
  // for shorter ones.
  always_comb begin
    coef_wide = ((int'(coef_q15(ctl.coef_idx)) <<< UP) + RND) >>> DN;
    coef      = COEF_BITS'(coef_wide);
    s_ext     = {{COEF_BITS{1'b0}}, 1'b0, sample};
    c_ext     = {{(SAMPLE_W + 1){coef[COEF_BITS-1]}}, coef};
    prod_nxt  = s_ext * c_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else if (ctl.clear) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctl.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

/* sv/flpd_pwm.sv */
// Converts the accumulated sum to a saturated Q.15 value and a clamped PWM compare value.
`default_nettype none

module flpd_pwm
  import flpd_pkg::*;
#(
  parameter int TAPS      = 31,
  parameter int COEF_BITS = 16,
  localparam int ACC_W    = COEF_BITS + SAMPLE_W + 1 + $clog2(TAPS + 1)
) (
  input  wire logic                    clk,
  input  wire pwm_ctl_t                ctl,
  input  wire logic signed [ACC_W-1:0] acc,
  input  wire logic [PWM_W-1:0]        full_scale,
  output logic signed [Q15_W-1:0]      q15_sat,
  output logic [PWM_W-1:0]             pwm
);

  localparam int FRAC   = COEF_BITS - 1;
  localparam int SHL    = (FRAC < 15) ? 15 - FRAC : 0;
  localparam int SHR    = (FRAC > 15) ? FRAC - 15 : 0;
  localparam int Q_W    = ACC_W + 8;
  localparam int PPROD_W = PWM_X_W + PWM_W;
  localparam logic signed [Q_W-1:0] Q_HI  = Q_W'(Q15_MAX_VAL);
  localparam logic signed [Q_W-1:0] Q_LO  = Q_W'(Q15_MIN_VAL);
  localparam logic signed [Q_W-1:0] X_LIM = Q_W'((1 << PWM_SHIFT) - 1);

  logic signed [Q_W-1:0]     acc_ext;
  logic signed [Q_W-1:0]     q15;
  logic signed [Q15_W-1:0]   sat_nxt;
  logic [PWM_X_W-1:0]        x_nxt;
  logic signed [Q15_W-1:0]   sat_r;
  logic [PWM_X_W-1:0]        x_r;
  logic [PPROD_W-1:0]        pprod_nxt;
  logic [PPROD_W-1:0]        pprod_r;
  logic [PWM_W:0]            mapped;

  always_comb begin
    acc_ext = Q_W'(acc);
    q15     = (acc_ext <<< SHL) >>> SHR;
    if (q15 > Q_HI) begin
      sat_nxt = Q15_W'(Q_HI);
    end else if (q15 < Q_LO) begin
      sat_nxt = Q15_W'(Q_LO);
    end else begin
      sat_nxt = q15[Q15_W-1:0];
    end
    // Anything at or beyond 2^27 maps to full scale or past it, so it is pinned to exactly 2^27.
    if (q15[Q_W-1] || (q15 == '0)) begin
      x_nxt = '0;
    end else if (q15 > X_LIM) begin
      x_nxt = {1'b1, {(PWM_X_W - 1){1'b0}}};
    end else begin
      x_nxt = q15[PWM_X_W-1:0];
    end
    pprod_nxt = {{PWM_W{1'b0}}, x_r} * {{PWM_X_W{1'b0}}, full_scale};
    mapped    = pprod_r[PPROD_W-1:PWM_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (ctl.scale_en) begin
      sat_r <= sat_nxt;
      x_r   <= x_nxt;
    end
    if (ctl.mul_en) begin
      pprod_r <= pprod_nxt;
    end
  end

  always_comb begin
    q15_sat = sat_r;
    if (full_scale == '0) begin
      pwm = '0;
    end else if (mapped >= {1'b0, full_scale}) begin
      pwm = full_scale - 1'b1;
    end else begin
      pwm = mapped[PWM_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* sv/fir_lowpass_to_pwm_duty.sv */
// Top level of the 31-tap low-pass FIR filter that drives a PWM compare value.
`default_nettype none

// This block filters 12-bit ADC samples with a fixed low-pass FIR and maps the result
// onto a PWM compare value. Each accepted request shifts its sample into a row of TAPS
// delay cells, which then rotate once around the ring, presenting one stored sample per
// cycle to a single shared multiplier that accumulates the coefficient products. An item
// therefore passes through these steps in order: loading the sample, one multiplication
// per tap, draining the last product into the accumulator, converting to Q.15 and
// saturating, the PWM scaling multiply, and loading the output register. The next
// request can be accepted only once the output register has been loaded, since the one
// multiplier walking the cell ring serves one sample at a time. A new sample is taken
// while a finished result still waits in the output register; the result is handed
// over as soon as that register is free. filtered_q15 is the FIR sum with 15 fraction
// bits, saturated to 26 bits, and pwm_compare is floor(sum * pwm_full_scale / 2^27)
// computed from the unsaturated sum, forced to zero for a negative sum and to
// pwm_full_scale - 1 at or above full scale. The pwm_full_scale register resets to
// 16000 and should only be written while the block holds no request in flight.

module fir_lowpass_to_pwm_duty
  import flpd_pkg::*;
#(
  parameter int TAPS      = 31,
  parameter int COEF_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // Sample requests.
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [SAMPLE_W-1:0]     in_sample,
  // Filter results.
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [Q15_W-1:0]      out_filtered_q15,
  output logic [PWM_W-1:0]             out_pwm_compare,
  // Full-scale register write.
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [PWM_W-1:0]        cfg_pwm_full_scale
);

  localparam int IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int ACC_W = COEF_BITS + SAMPLE_W + 1 + $clog2(TAPS + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TAPS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_SCALE,
    S_MUL,
    S_OUT
  } state_t;

  state_t                   state_r;
  logic [IDX_W-1:0]         idx_r;
  logic [PWM_W-1:0]         fs_r;
  logic                     out_valid_r;
  logic signed [Q15_W-1:0]  out_q15_r;
  logic [PWM_W-1:0]         out_pwm_r;

  logic                     accept;
  logic                     shift_en;
  logic [SAMPLE_W-1:0]      cell_q [TAPS];
  logic [SAMPLE_W-1:0]      cell_d [TAPS];
  mac_ctl_t                 mac_ctl;
  pwm_ctl_t                 pwm_ctl;
  logic signed [ACC_W-1:0]  acc;
  logic signed [Q15_W-1:0]  q15_sat;
  logic [PWM_W-1:0]         pwm;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // The row moves on a new sample and during every multiply cycle. While multiplying,
  // the last cell wraps to the first, so once the multiply pass ends the row is back in order.
  assign shift_en = accept || (state_r == S_MAC);

  always_comb begin
    cell_d[0] = accept ? in_sample : cell_q[TAPS-1];
    for (int i = 1; i < TAPS; i++) begin
      cell_d[i] = cell_q[i-1];
    end
  end

  for (genvar g = 0; g < TAPS; g++) begin : g_cell
    flpd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .d_in     (cell_d[g]),
      .q        (cell_q[g])
    );
  end

  // After k rotations the last cell holds the sample of tap TAPS-1-k, so the
  // coefficient index counts down from the last tap to tap zero.
  always_comb begin
    mac_ctl.clear    = accept;
    mac_ctl.mul_en   = (state_r == S_MAC);
    mac_ctl.coef_idx = COEF_IDX_W'(idx_r);
    pwm_ctl.scale_en = (state_r == S_SCALE);
    pwm_ctl.mul_en   = (state_r == S_MUL);
  end

  flpd_mac #(
    .TAPS      (TAPS),
    .COEF_BITS (COEF_BITS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .sample (cell_q[TAPS-1]),
    .acc    (acc)
  );

  flpd_pwm #(
    .TAPS      (TAPS),
    .COEF_BITS (COEF_BITS)
  ) u_pwm (
    .clk        (clk),
    .ctl        (pwm_ctl),
    .acc        (acc),
    .full_scale (fs_r),
    .q15_sat    (q15_sat),
    .pwm        (pwm)
  );

  // Sequencer, configuration register and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      fs_r        <= PWM_FS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        fs_r <= cfg_pwm_full_scale;
      end
      // In the output state the new result takes over the register instead.
      if (out_valid_r && !out_stall && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            idx_r   <= IDX_LAST;
            state_r <= S_MAC;
          end
        end
        S_MAC: begin
          if (idx_r == '0) begin
            state_r <= S_DRAIN;
          end else begin
            idx_r <= idx_r - 1'b1;
          end
        end
        S_DRAIN: begin
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_q15_r   <= q15_sat;
            out_pwm_r   <= pwm;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_filtered_q15 = out_q15_r;
  assign out_pwm_compare  = out_pwm_r;

  // A new sample always starts the multiply pass at the last tap.
  a_start_pass: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_MAC) && (idx_r == IDX_LAST))
    else $error("multiply pass did not start at the last tap");

  // The multiply pass ends after tap zero and hands over to the drain cycle.
  a_end_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) && (idx_r == '0) |=> (state_r == S_DRAIN))
    else $error("multiply pass did not end after tap zero");

  // The compare value stays below full scale.
  a_pwm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (fs_r != '0) |-> (out_pwm_compare < fs_r))
    else $error("PWM compare value reached full scale");

  // A negative filter output gives a zero compare value.
  a_pwm_negative: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_filtered_q15[Q15_W-1] |-> (out_pwm_compare == '0))
    else $error("negative filter output gave a nonzero compare value");

endmodule

`default_nettype wire

/* tb/sv/fir_lowpass_to_pwm_duty_test.sv */
// Self-checking testbench for the FIR low-pass filter with PWM compare output.
`timescale 1ns / 100ps

// The sample requests and the full-scale writes are driven on the falling clock edge.
// All handshakes and results are sampled on the rising edge, so no check depends on the
// order of events within one time step. A behavioral copy of the filter runs inside the
// testbench. Every accepted sample request updates that copy's delay line and queues the
// expected filter result. A checker process compares each accepted result, field by field,
// against the oldest queued expectation. The full-scale register is only written once
// every queued result has come back. Each result has exactly one request behind it, so
// an empty queue means that the block is idle.

module fir_lowpass_to_pwm_duty_test;
  import flpd_pkg::*;

  localparam int TAP_COUNT    = 31;
  // The tail is long enough to cover one more request through the block.
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_OFF_CYCLES = 300;

  // Shapes of the random sample streams. Low-pass behavior shows best with steps,
  // holds and square waves, so noise is only one of several shapes.
  typedef enum logic [1:0] {
    WAVE_NOISE,
    WAVE_HOLD,
    WAVE_SQUARE,
    WAVE_DRIFT
  } wave_shape_t;

  typedef struct {
    logic signed [Q15_W-1:0] filtered;
    logic [PWM_W-1:0]        pwm;
  } filter_result_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [SAMPLE_W-1:0]     in_sample;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [Q15_W-1:0] out_filtered_q15;
  logic [PWM_W-1:0]        out_pwm_compare;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [PWM_W-1:0]        cfg_pwm_full_scale;

  // This is the testbench's own copy of the filter state and of the full-scale register.
  int                      lowpass_coef [TAP_COUNT];
  logic [SAMPLE_W-1:0]     sample_line [TAP_COUNT];
  logic [PWM_W-1:0]        model_full_scale;
  filter_result_t          pending_results [$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_off_left;
  int error_count;
  int cycle_count;

  fir_lowpass_to_pwm_duty dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_filtered_q15   (out_filtered_q15),
    .out_pwm_compare    (out_pwm_compare),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_pwm_full_scale (cfg_pwm_full_scale)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // The run is stopped at a generous cycle limit in case a handshake never completes.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // The result receiver stalls at random. During a hold-off it keeps the stall high until
  // the hold-off counter runs out, so that the block fills up and stalls its input.
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_stall <= 1'b1;
      hold_off_left <= hold_off_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // The checker compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    filter_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request pending: filtered %0d pwm %0d",
                 $time, out_filtered_q15, out_pwm_compare);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_filtered_q15 !== exp_res.filtered) begin
          $display("%0t: filtered_q15 mismatch: expected %0d actual %0d",
                   $time, exp_res.filtered, out_filtered_q15);
          error_count++;
        end
        if (out_pwm_compare !== exp_res.pwm) begin
          $display("%0t: pwm_compare mismatch: expected %0d actual %0d",
                   $time, exp_res.pwm, out_pwm_compare);
          error_count++;
        end
      end
    end
  end

  // The sample is shifted into the delay line and the expected result is queued.
  // The newest sample sits at tap 0. Both the sum and the PWM value keep full width.
  // The sum is then saturated to 26 bits, and the PWM value is taken from the
  // unsaturated sum.
  function automatic void predict_filter(input logic [SAMPLE_W-1:0] s);
    longint         acc;
    longint         duty;
    filter_result_t res;
    acc = 0;
    duty = 0;
    for (int i = TAP_COUNT - 1; i > 0; i--) sample_line[i] = sample_line[i-1];
    sample_line[0] = s;
    for (int i = 0; i < TAP_COUNT; i++) begin
      acc += longint'(lowpass_coef[i]) * longint'(sample_line[i]);
    end
    if (acc > Q15_MAX_VAL) res.filtered = Q15_W'(Q15_MAX_VAL);
    else if (acc < Q15_MIN_VAL) res.filtered = Q15_W'(Q15_MIN_VAL);
    else res.filtered = acc[Q15_W-1:0];
    // A negative sum and a zero full scale both give a zero compare value.
    if (acc > 0 && model_full_scale != 0) begin
      duty = (acc * longint'(model_full_scale)) >>> PWM_SHIFT;
      if (duty >= longint'(model_full_scale)) duty = longint'(model_full_scale) - 1;
    end
    res.pwm = duty[PWM_W-1:0];
    pending_results.push_back(res);
  endfunction

  // One sample request is offered, after a random gap, and held until it is accepted.
  // Valid stays high after acceptance. The next request or a drain lowers or reuses it
  // on the next falling edge.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_sample <= SAMPLE_W'($urandom);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    predict_filter(s);
  endtask

  // The sender stops and waits until every expected result has come back.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // The full-scale register is written only while the block is idle.
  task automatic write_full_scale(input logic [PWM_W-1:0] value);
    wait_for_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_pwm_full_scale <= value;
    do @(posedge clk); while (!cfg_ready);
    model_full_scale = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_pwm_full_scale <= PWM_W'($urandom);
  endtask

  // Random samples are sent in segments of noise, holds, square waves and slow drift.
  // Square waves with long periods fill the positive taps and drive the sum into
  // saturation. Short bursts of full scale make the sum negative.
  task automatic run_random_samples(input int count);
    wave_shape_t         shape;
    int                  seg_left;
    int                  level;
    int                  period;
    int                  phase;
    int                  n;
    logic [SAMPLE_W-1:0] s;
    shape = WAVE_NOISE;
    seg_left = 0;
    level = 0;
    period = 1;
    phase = 0;
    for (n = 0; n < count; n++) begin
      if (seg_left == 0) begin
        shape = wave_shape_t'($urandom_range(3));
        seg_left = int'($urandom_range(8, 48));
        level = ($urandom_range(3) == 0) ? 4095 * int'($urandom_range(1))
                                         : int'($urandom_range(4095));
        period = int'($urandom_range(1, 20));
        phase = 0;
      end
      case (shape)
        WAVE_NOISE: begin
          s = SAMPLE_W'($urandom_range(4095));
        end
        WAVE_HOLD: begin
          s = level[SAMPLE_W-1:0];
        end
        WAVE_SQUARE: begin
          s = ((phase / period) % 2 == 0) ? 12'hFFF : 12'h000;
        end
        default: begin
          level = level + int'($urandom_range(64)) - 32;
          if (level < 0) level = 0;
          if (level > 4095) level = 4095;
          s = level[SAMPLE_W-1:0];
        end
      endcase
      phase++;
      seg_left--;
      send_sample(s);
    end
  endtask

  // Straight after reset the delay line is clear and the full scale is 16000. A run of
  // full-scale samples first loads only the negative taps, which gives a negative sum
  // and a zero compare value. It then reaches the first positive taps. Zeros that follow
  // flush the negative taps, so that only positive taps hold samples. That sum
  // exceeds the 26-bit range and must saturate, while the PWM value still comes
  // from the full sum.
  task automatic test_reset_state_and_saturation();
    send_sample(12'h000);
    repeat (13) send_sample(12'hFFF);
    repeat (9) send_sample(12'h000);
  endtask

  // With a zero full scale the compare value must be zero even for a large positive sum.
  task automatic test_zero_full_scale();
    write_full_scale('0);
    send_sample(12'h000);
    send_sample(12'hFFF);
  endtask

  // A random phase with its own idle rates and full-scale setting.
  task automatic test_random_phase(input int count, input int s_pct, input int r_pct,
                                   input logic [PWM_W-1:0] full_scale);
    write_full_scale(full_scale);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    run_random_samples(count);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering requests.
  // The block must stall its input and lose nothing. Afterwards the sender pauses until
  // every result is back.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    hold_off_left = HOLD_OFF_CYCLES;
    run_random_samples(20);
    wait_for_results();
  endtask

  // Without any idling, several random full-scale settings are exercised back to back.
  task automatic test_unthrottled_sweep();
    repeat (3) test_random_phase(130, 0, 0, PWM_W'($urandom_range(1, 65535)));
  endtask

  initial begin
    in_valid = 1'b0;
    in_sample = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_pwm_full_scale = '0;
    rst_n = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_left = 0;
    error_count = 0;
    cycle_count = 0;
    lowpass_coef = '{-36, -75, -115, -147, -167, -170, -147, -95,
                     0, 138, 311, 505, 698, 868, 999, 1065,
                     1065, 999, 868, 698, 505, 311, 138, 0,
                     -95, -147, -170, -167, -147, -115, -75};
    for (int i = 0; i < TAP_COUNT; i++) sample_line[i] = '0;
    model_full_scale = PWM_FS_RESET;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state_and_saturation();
    test_zero_full_scale();
    test_random_phase(420, 22, 63, 16'hFFFF);
    test_output_backpressure();
    test_random_phase(420, 63, 22, 16'd1);
    test_unthrottled_sweep();

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
